FILE: sv/iba_pkg.sv
// ----------------------------------------------------------------------------
// iba_pkg
// Shared types, codes and helpers for the indexed block allocator.
// ----------------------------------------------------------------------------
package iba_pkg;

   // Default sizes, handed to the top level as parameter defaults
   localparam int NUM_BLOCKS_DEF = 128;
   localparam int MAX_INDEX_DEF  = 16;

   // The map memory holds this many blocks per row
   localparam int ROW_BITS = 8;
   localparam int OFF_W    = $clog2(ROW_BITS);

   // Field widths
   localparam int BLOCK_W  = 7;
   localparam int LENGTH_W = 5;
   localparam int ENTRY_W  = 4;

   typedef enum logic {
      ACT_MARK  = 1'b0,
      ACT_ALLOC = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      STAT_ALLOCATED  = 3'd0,
      STAT_START_USED = 3'd1,
      STAT_NO_SPACE   = 3'd2,
      STAT_BAD_LENGTH = 3'd3,
      STAT_MARK_DONE  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MARK,
      S_COUNT,
      S_ALOAD,
      S_AEMIT
   } state_type;

   typedef struct packed {
      action_type           action;
      logic [BLOCK_W-1:0]   block_number;
      logic [LENGTH_W-1:0]  length;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [ENTRY_W-1:0]   entry_index;
      logic [BLOCK_W-1:0]   block_location;
      logic                 last;
   } rsp_type;

   // Number of set bits in one row
   function automatic logic [OFF_W:0] row_popcount(input logic [ROW_BITS-1:0] bits);
      logic [OFF_W:0] acc;
      acc = '0;
      for (int i = 0; i < ROW_BITS; i++) begin
         acc = acc + (OFF_W+1)'(bits[i]);
      end
      return acc;
   endfunction

   // Position of the lowest set bit in one row (zero when none is set)
   function automatic logic [OFF_W-1:0] row_first_set(input logic [ROW_BITS-1:0] bits);
      logic [OFF_W-1:0] pos;
      pos = '0;
      for (int i = ROW_BITS - 1; i >= 0; i--) begin
         if (bits[i]) begin
            pos = OFF_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

FILE: sv/iba_map_mem.sv
// ----------------------------------------------------------------------------
// iba_map_mem
// Used-block map: one synchronous row memory with a registered read and
// per-row valid bits, so that a row never written reads as all free.
// ----------------------------------------------------------------------------
module iba_map_mem #(
   parameter int ROWS   = 16,
   parameter int ROW_AW = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [ROW_AW-1:0]              rd_addr,
   output logic [iba_pkg::ROW_BITS-1:0]   rd_data,
   input  logic                           wr_en,
   input  logic [ROW_AW-1:0]              wr_addr,
   input  logic [iba_pkg::ROW_BITS-1:0]   wr_data
);
   import iba_pkg::*;

   logic [ROW_BITS-1:0] mem [ROWS];
   logic [ROWS-1:0]     valid_ff;
   logic [ROW_BITS-1:0] rd_word_ff;
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // rows never written read as free
   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

FILE: sv/indexed_block_allocator.sv
// ----------------------------------------------------------------------------
// indexed_block_allocator
// Free/used bitmap of disk blocks with mark and indexed-file allocation.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_data and raise start; the transaction is taken at a clock edge
//   where start is high and busy is low. busy stays high until every result
//   of that transaction has been produced.
//   Results leave on rsp_data with rsp_valid high for exactly one cycle each;
//   the receiver cannot stall, so results are never held back.
//   A mark gives one result (status mark done). An allocation gives either a
//   single rejection result or one result per block taken, in ascending
//   block order, with last set on the final one.
// Sequence:
//   The map sits in a row memory of eight blocks per row behind one
//   registered read port. A mark writes back its row with the block set.
//   An allocation sweeps rows from the start row counting free blocks,
//   then returns to the start row and takes blocks, loading each row and
//   emitting from it. A used start block or a bad length is rejected on
//   the start row, and no space once the last row is swept. A new
//   transaction is taken only in idle. Each result appears on rsp_data
//   the cycle after it is formed (output register).
// Reset:
//   Synchronous reset clears the row valid bits, so every block reads free
//   immediately; no clearing pass is needed.
// ----------------------------------------------------------------------------
module indexed_block_allocator #(
   parameter int NUM_BLOCKS = iba_pkg::NUM_BLOCKS_DEF,
   parameter int MAX_INDEX  = iba_pkg::MAX_INDEX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  iba_pkg::req_type  req_data,
   output logic              rsp_valid,
   output iba_pkg::rsp_type  rsp_data
);
   import iba_pkg::*;

   localparam int ROWS     = (NUM_BLOCKS + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CNT_W    = $clog2(MAX_INDEX + ROW_BITS + 1);
   localparam int K_W      = $clog2(MAX_INDEX + 1);
   localparam int TAIL     = NUM_BLOCKS % ROW_BITS;
   localparam logic [ROW_AW-1:0]   LAST_ROW  = ROW_AW'(ROWS - 1);
   localparam logic [ROW_BITS-1:0] LAST_MASK =
      (TAIL == 0) ? {ROW_BITS{1'b1}} : ROW_BITS'((1 << TAIL) - 1);

   state_type             state_ff, state_in;
   logic [ROW_AW-1:0]     row_ff, row_in;
   logic [ROW_AW-1:0]     start_row_ff, start_row_in;
   logic                  first_ff, first_in;
   logic [OFF_W-1:0]      off_ff, off_in;
   logic [LENGTH_W-1:0]   len_ff, len_in;
   logic [BLOCK_W-1:0]    blk_ff, blk_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [K_W-1:0]        k_ff, k_in;
   logic [ROW_BITS-1:0]   word_ff, word_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  rd_en;
   logic [ROW_AW-1:0]     rd_addr;
   logic [ROW_BITS-1:0]   rd_data;
   logic                  wr_en;
   logic [ROW_AW-1:0]     wr_addr;
   logic [ROW_BITS-1:0]   wr_data;

   logic [ROW_BITS-1:0]   elig;
   logic [ROW_BITS-1:0]   free_bits;
   logic [ROW_BITS-1:0]   cand;
   logic [OFF_W-1:0]      pick;
   logic [ROW_BITS-1:0]   pick_bit;
   logic [CNT_W-1:0]      cnt_next;
   logic                  len_bad;
   logic                  in_range;
   logic [ROW_AW-1:0]     req_row;

   iba_map_mem #(
      .ROWS   (ROWS),
      .ROW_AW (ROW_AW)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Blocks of the current row that belong to the search: at or after the
   // start block on the first row, and inside the map on the final row.
   always_comb begin
      elig = {ROW_BITS{1'b1}};
      if (first_ff) begin
         elig = elig & ({ROW_BITS{1'b1}} << off_ff);
      end
      if (row_ff == LAST_ROW) begin
         elig = elig & LAST_MASK;
      end
   end

   assign free_bits = ~rd_data & elig;
   assign cnt_next  = cnt_ff + CNT_W'(row_popcount(free_bits));
   assign cand      = ~word_ff & elig;
   assign pick      = row_first_set(cand);
   assign pick_bit  = ROW_BITS'(1) << pick;
   assign len_bad   = (len_ff == '0) || (32'(len_ff) > MAX_INDEX);
   assign in_range  = 32'(req_data.block_number) < NUM_BLOCKS;
   assign req_row   = ROW_AW'(32'(req_data.block_number) >> OFF_W);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      start_row_in = start_row_ff;
      first_in     = first_ff;
      off_in       = off_ff;
      len_in       = len_ff;
      blk_in       = blk_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      word_in      = word_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '{status: STAT_ALLOCATED, entry_index: '0,
                       block_location: '0, last: 1'b1};
      rd_en        = 1'b0;
      rd_addr      = row_ff + ROW_AW'(1);
      wr_en        = 1'b0;
      wr_addr      = row_ff;
      wr_data      = word_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               // capture the transaction and fetch the row holding its block
               len_in       = req_data.length;
               off_in       = req_data.block_number[OFF_W-1:0];
               blk_in       = req_data.block_number;
               row_in       = req_row;
               start_row_in = req_row;
               first_in     = 1'b1;
               cnt_in       = '0;
               k_in         = '0;
               rd_en        = in_range;
               rd_addr      = req_row;
               if (req_data.action == ACT_MARK) begin
                  if (in_range) begin
                     state_in = S_MARK;
                  end else begin
                     // out-of-range mark: report, leave the map alone
                     rsp_valid_in          = 1'b1;
                     rsp_in.status         = STAT_MARK_DONE;
                     rsp_in.block_location = req_data.block_number;
                  end
               end else begin
                  if (in_range) begin
                     state_in = S_COUNT;
                  end else begin
                     // nothing lies at or after an out-of-range start
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ((req_data.length == '0) ||
                                      (32'(req_data.length) > MAX_INDEX)) ?
                                     STAT_BAD_LENGTH : STAT_NO_SPACE;
                  end
               end
            end
         end

         S_MARK: begin
            // write back the row with the block set
            wr_en                 = 1'b1;
            wr_addr               = row_ff;
            wr_data               = rd_data | (ROW_BITS'(1) << off_ff);
            rsp_valid_in          = 1'b1;
            rsp_in.status         = STAT_MARK_DONE;
            rsp_in.block_location = blk_ff;
            state_in              = S_IDLE;
         end

         S_COUNT: begin
            priority if (first_ff && rd_data[off_ff]) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STAT_START_USED;
               state_in      = S_IDLE;
            end else if (first_ff && len_bad) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STAT_BAD_LENGTH;
               state_in      = S_IDLE;
            end else if (32'(cnt_next) >= 32'(len_ff)) begin
               // enough room: go back to the start row and take blocks
               rd_en    = 1'b1;
               rd_addr  = start_row_ff;
               row_in   = start_row_ff;
               first_in = 1'b1;
               state_in = S_ALOAD;
            end else if (row_ff == LAST_ROW) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STAT_NO_SPACE;
               state_in      = S_IDLE;
            end else begin
               // advance to the next row, one row per cycle
               rd_en    = 1'b1;
               rd_addr  = row_ff + ROW_AW'(1);
               row_in   = row_ff + ROW_AW'(1);
               first_in = 1'b0;
               cnt_in   = cnt_next;
            end
         end

         S_ALOAD: begin
            word_in  = rd_data;
            state_in = S_AEMIT;
         end

         S_AEMIT: begin
            if (|cand) begin
               // take the lowest free block, one per cycle until the row is exhausted
               rsp_valid_in          = 1'b1;
               rsp_in.status         = STAT_ALLOCATED;
               rsp_in.entry_index    = ENTRY_W'(k_ff);
               rsp_in.block_location = BLOCK_W'({row_ff, pick});
               rsp_in.last           = 1'b0;
               word_in               = word_ff | pick_bit;
               k_in                  = k_ff + K_W'(1);
               if (32'(k_ff) + 1 == 32'(len_ff)) begin
                  rsp_in.last = 1'b1;
                  wr_en       = 1'b1;
                  wr_data     = word_ff | pick_bit;
                  state_in    = S_IDLE;
               end
            end else begin
               // row exhausted: write it back and fetch the next one
               wr_en    = 1'b1;
               wr_data  = word_ff;
               rd_en    = 1'b1;
               rd_addr  = row_ff + ROW_AW'(1);
               row_in   = row_ff + ROW_AW'(1);
               first_in = 1'b0;
               state_in = S_ALOAD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      start_row_ff <= start_row_in;
      first_ff     <= first_in;
      off_ff       <= off_in;
      len_ff       <= len_in;
      blk_ff       <= blk_in;
      cnt_ff       <= cnt_in;
      k_ff         <= k_in;
      word_ff      <= word_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
